[hdl/spfg_pkg.sv]
// Shared types and constants for the servo pulse frame generator.
package spfg_pkg;

	localparam int WIDTH_W      = 13;
	localparam int CENTER_W     = 12;
	localparam int FRAME_W      = 16;
	localparam int CH_W         = 3;
	localparam int PIN_W        = 6;
	localparam int ROUTE_BITS   = 7;
	localparam int ROUTE_MAX    = 5;
	localparam int CFG_DATA_W   = ROUTE_BITS * ROUTE_MAX;
	localparam int CFG_INDEX_W  = 3;
	localparam int CHAIN_FIRST  = 3;
	localparam int CHAIN_STEPS  = 4;

	localparam int OUTPUTS_DEF        = 6;
	localparam int INPUT_CHANNELS_DEF = 8;
	localparam int ROUTES_DEF         = 5;

	localparam logic [WIDTH_W-1:0]    RESET_WIDTH      = 13'd3000;
	localparam logic [FRAME_W-1:0]    FRAME_PERIOD_RST = 16'd50000;
	localparam logic [CENTER_W-1:0]   CENTER_RST       = 12'd3000;
	localparam logic [CENTER_W-1:0]   RANGE_RST        = 12'd1000;
	localparam logic [FRAME_W-1:0]    STARTUP_RST      = 16'd400;

	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_PERIOD   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SERVO_CENTER   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SERVO_RANGE    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_STARTUP_FRAMES = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_ROUTE_TABLE    = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_ROUTE_ENABLE   = 3'd5;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	typedef struct packed {
		logic               action;
		logic [CH_W-1:0]    channel;
		logic [WIDTH_W-1:0] width;
	} item_t;

	typedef struct packed {
		logic [PIN_W-1:0] pin_levels;
		logic             frame_start;
		logic             startup_done;
	} result_t;

	typedef struct packed {
		logic [CENTER_W-1:0]   center;
		logic [CENTER_W-1:0]   range;
		logic [CFG_DATA_W-1:0] table_bits;
		logic [ROUTE_MAX-1:0]  enable;
	} route_cfg_t;

	typedef struct packed {
		logic [CH_W-1:0]    index;
		logic [WIDTH_W-1:0] count;
	} chain_t;

endpackage

[hdl/spfg_route.sv]
// Frame-start routing: copy or mirror input widths, clamp, and merge into output widths.
module spfg_route import spfg_pkg::*; #(
	parameter int OUTPUTS        = OUTPUTS_DEF,
	parameter int INPUT_CHANNELS = INPUT_CHANNELS_DEF,
	parameter int ROUTES         = ROUTES_DEF
) (
	input  route_cfg_t         cfg,
	input  logic [WIDTH_W-1:0] in_widths [INPUT_CHANNELS],
	input  logic [WIDTH_W-1:0] cur_widths[OUTPUTS],
	output logic [WIDTH_W-1:0] new_widths[OUTPUTS]
);

	localparam int V_W = WIDTH_W + 2;

	logic [WIDTH_W-1:0]  hi;
	logic [WIDTH_W-1:0]  lo;
	logic [WIDTH_W-1:0]  route_val[ROUTES];
	logic                route_hit[ROUTES];
	logic [CH_W-1:0]     route_och[ROUTES];

	// c + r tops out at 8190, so the upper bound never needs the 8191 cap
	assign hi = WIDTH_W'({1'b0, cfg.center} + {1'b0, cfg.range});
	assign lo = (cfg.center >= cfg.range) ? WIDTH_W'(cfg.center - cfg.range) : '0;

	always_comb begin
		logic [ROUTE_BITS-1:0] bits;
		logic [CH_W-1:0]       ich;
		logic [WIDTH_W-1:0]    sel;
		logic                  found;
		logic signed [V_W-1:0] v;
		for (int r = 0; r < ROUTES; r++) begin
			bits  = cfg.table_bits[ROUTE_BITS*r +: ROUTE_BITS];
			ich   = bits[CH_W-1:0];
			sel   = '0;
			found = 1'b0;
			for (int i = 0; i < INPUT_CHANNELS; i++) begin
				if (ich == CH_W'(i)) begin
					sel   = in_widths[i];
					found = 1'b1;
				end
			end
			if (bits[ROUTE_BITS-1])
				v = $signed({2'b00, cfg.center, 1'b0}) - $signed({2'b00, sel});
			else
				v = $signed({2'b00, sel});
			if (v < $signed({2'b00, lo}))
				route_val[r] = lo;
			else if (v > $signed({2'b00, hi}))
				route_val[r] = hi;
			else
				route_val[r] = v[WIDTH_W-1:0];
			route_hit[r] = cfg.enable[r] && found;
			route_och[r] = bits[2*CH_W-1:CH_W];
		end
	end

	// later routes to the same output win
	always_comb begin
		for (int o = 0; o < OUTPUTS; o++) begin
			new_widths[o] = cur_widths[o];
			for (int r = 0; r < ROUTES; r++) begin
				if (route_hit[r] && route_och[r] == CH_W'(o))
					new_widths[o] = route_val[r];
			end
		end
	end

endmodule

[hdl/spfg_pins.sv]
// Pin levels for one tick: parallel outputs against the frame count, chained outputs in turn.
module spfg_pins import spfg_pkg::*; #(
	parameter int OUTPUTS = OUTPUTS_DEF
) (
	input  logic [FRAME_W-1:0] frame_count,
	input  logic               start,
	input  logic [WIDTH_W-1:0] widths[OUTPUTS],
	input  chain_t             chain_cur,
	output chain_t             chain_next,
	output logic [PIN_W-1:0]   pins
);

	always_comb begin
		logic [CH_W-1:0]    idx;
		logic [WIDTH_W-1:0] cnt;
		logic [WIDTH_W-1:0] wsel;
		logic               done;
		pins = '0;
		for (int i = 0; i < CHAIN_FIRST; i++) begin
			if (frame_count < {{(FRAME_W-WIDTH_W){1'b0}}, widths[i]})
				pins[i] = 1'b1;
		end

		if (start) begin
			idx = (OUTPUTS > CHAIN_FIRST) ? CH_W'(CHAIN_FIRST) : '0;
			cnt = '0;
		end else begin
			idx = chain_cur.index;
			cnt = chain_cur.count;
		end

		// skip finished (or zero-width) outputs; falls off the end to idle
		done = 1'b0;
		for (int k = 0; k < CHAIN_STEPS; k++) begin
			wsel = '0;
			for (int j = 0; j < OUTPUTS; j++)
				if (idx == CH_W'(j)) wsel = widths[j];
			if (!done && idx != '0) begin
				if (idx >= CH_W'(OUTPUTS)) begin
					idx  = '0;
					done = 1'b1;
				end else if (cnt < wsel) begin
					done = 1'b1;
				end else begin
					idx = idx + 1'b1;
					cnt = '0;
				end
			end
		end

		if (idx != '0) begin
			for (int j = 0; j < OUTPUTS; j++)
				if (idx == CH_W'(j)) pins[j] = 1'b1;
			cnt = cnt + 1'b1;
		end
		chain_next.index = idx;
		chain_next.count = cnt;
	end

endmodule

[hdl/servo_pulse_frame_generator.sv]
// Top level: config registers, frame state, routing and pin logic, result register.
//
//  channel   direction  handshake              payload
//  item      in         item_valid/item_stall  item_t   (action, channel, width)
//  result    out        result_valid/result_stall  result_t (pin_levels, frame_start, startup_done)
//  cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One item per cycle while item_stall is low; its result appears in the result register on the next cycle.
// The state update and the result are computed by the routing and pin logic and registered in the same cycle.
// arst_n clears the config and frame state to power-up values (result_q is not reset); widths start at 3000 ticks.
// item_stall is raised only while a result is held and result_stall is high.
// cfg_ready is always high.
module servo_pulse_frame_generator import spfg_pkg::*; #(
	parameter int OUTPUTS        = OUTPUTS_DEF,
	parameter int INPUT_CHANNELS = INPUT_CHANNELS_DEF,
	parameter int ROUTES         = ROUTES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  item_t                  item,
	output logic                   result_valid,
	input  logic                   result_stall,
	output result_t                result,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [FRAME_W-1:0]    frame_period_q;
	route_cfg_t            route_cfg_q;

	logic [WIDTH_W-1:0]    iw_q[INPUT_CHANNELS];
	logic [WIDTH_W-1:0]    ow_q[OUTPUTS];
	logic [WIDTH_W-1:0]    ow_routed[OUTPUTS];
	logic [WIDTH_W-1:0]    ow_eff[OUTPUTS];
	logic [FRAME_W-1:0]    frame_count_q;
	chain_t                chain_q;
	chain_t                chain_next;
	logic [FRAME_W-1:0]    startup_left_q;
	logic [FRAME_W-1:0]    startup_next;
	logic [PIN_W-1:0]      last_pins_q;
	logic [PIN_W-1:0]      tick_pins;

	logic                  result_valid_q;
	result_t               result_q;

	logic                  accept;
	logic                  tick;
	logic                  start;
	logic                  cfg_we;
	logic [FRAME_W-1:0]    period;
	logic [FRAME_W-1:0]    frame_next;

	assign cfg_ready    = 1'b1;
	assign cfg_we       = cfg_valid && cfg_ready;
	assign item_stall   = result_valid_q && result_stall;
	assign accept       = item_valid && !item_stall;
	assign tick         = accept && (item.action == ACT_TICK);
	assign start        = frame_count_q == '0;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	spfg_route #(
		.OUTPUTS       (OUTPUTS),
		.INPUT_CHANNELS(INPUT_CHANNELS),
		.ROUTES        (ROUTES)
	) u_route (
		.cfg       (route_cfg_q),
		.in_widths (iw_q),
		.cur_widths(ow_q),
		.new_widths(ow_routed)
	);

	always_comb begin
		for (int o = 0; o < OUTPUTS; o++)
			ow_eff[o] = start ? ow_routed[o] : ow_q[o];
	end

	spfg_pins #(
		.OUTPUTS(OUTPUTS)
	) u_pins (
		.frame_count(frame_count_q),
		.start      (start),
		.widths     (ow_eff),
		.chain_cur  (chain_q),
		.chain_next (chain_next),
		.pins       (tick_pins)
	);

	// zero period behaves as one
	assign period       = (frame_period_q == '0) ? FRAME_W'(1) : frame_period_q;
	assign frame_next   = ({1'b0, frame_count_q} + 1'b1 >= {1'b0, period}) ? '0
	                    : frame_count_q + 1'b1;
	assign startup_next = (start && startup_left_q != '0) ? startup_left_q - 1'b1
	                    : startup_left_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_period_q         <= FRAME_PERIOD_RST;
			route_cfg_q.center     <= CENTER_RST;
			route_cfg_q.range      <= RANGE_RST;
			route_cfg_q.table_bits <= '0;
			route_cfg_q.enable     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_PERIOD:   frame_period_q         <= cfg_data[FRAME_W-1:0];
				REG_SERVO_CENTER:   route_cfg_q.center     <= cfg_data[CENTER_W-1:0];
				REG_SERVO_RANGE:    route_cfg_q.range      <= cfg_data[CENTER_W-1:0];
				// reloads the countdown in the state block
				REG_STARTUP_FRAMES: ;
				REG_ROUTE_TABLE:    route_cfg_q.table_bits <= cfg_data;
				REG_ROUTE_ENABLE:   route_cfg_q.enable     <= cfg_data[ROUTE_MAX-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < INPUT_CHANNELS; i++) iw_q[i] <= RESET_WIDTH;
			for (int o = 0; o < OUTPUTS; o++) ow_q[o] <= RESET_WIDTH;
			frame_count_q  <= '0;
			chain_q        <= '0;
			startup_left_q <= STARTUP_RST;
			last_pins_q    <= '0;
		end else begin
			if (accept && item.action == ACT_LOAD) begin
				for (int i = 0; i < INPUT_CHANNELS; i++)
					if (item.channel == CH_W'(i)) iw_q[i] <= item.width;
			end
			if (tick) begin
				for (int o = 0; o < OUTPUTS; o++) ow_q[o] <= ow_eff[o];
				frame_count_q  <= frame_next;
				chain_q        <= chain_next;
				last_pins_q    <= tick_pins;
			end
			if (cfg_we && cfg_index == REG_STARTUP_FRAMES)
				startup_left_q <= cfg_data[FRAME_W-1:0];
			else if (tick)
				startup_left_q <= startup_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (accept) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (item.action == ACT_TICK) begin
				result_q.pin_levels   <= tick_pins;
				result_q.frame_start  <= start;
				result_q.startup_done <= startup_next == '0;
			end else begin
				result_q.pin_levels   <= last_pins_q;
				result_q.frame_start  <= 1'b0;
				result_q.startup_done <= startup_left_q == '0;
			end
		end
	end

	// chain sits idle or on one of the chained outputs
	a_chain_range: assert property (@(posedge clk) disable iff (!arst_n)
		chain_q.index == '0 ||
		(chain_q.index >= CH_W'(CHAIN_FIRST) && chain_q.index < CH_W'(OUTPUTS)))
		else $error("chain index out of range");

	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		tick && frame_count_q == '0 |=> result_valid_q && result_q.frame_start)
		else $error("frame start not reported");

	a_startup_dec: assert property (@(posedge clk) disable iff (!arst_n)
		tick && start && startup_left_q != '0 &&
		!(cfg_we && cfg_index == REG_STARTUP_FRAMES)
		|=> startup_left_q == $past(startup_left_q) - 1'b1)
		else $error("startup countdown missed a frame");

	a_load_holds_pins: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.action == ACT_LOAD |=> result_q.pin_levels == last_pins_q)
		else $error("load item changed pin levels");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid_q && !accept)
		else $error("input stalled with empty result register");

endmodule

[dv/servo_pulse_frame_generator_tb.sv]
// Self-checking testbench for the servo pulse frame generator: random traffic, scoreboard.
`timescale 1ns / 1ps

module servo_pulse_frame_generator_tb import spfg_pkg::*;;

	localparam int IDLE_LIMIT   = 4000;
	localparam int PHASE_ITEMS  = 170;
	localparam int PHASES       = 8;

	// Tracks the block's frame, routing and chain state and keeps the results still due.
	class frame_scoreboard;
		logic [FRAME_W-1:0]    period_reg;
		logic [CENTER_W-1:0]   center_reg;
		logic [CENTER_W-1:0]   span_reg;
		logic [FRAME_W-1:0]    startup_reg;
		logic [CFG_DATA_W-1:0] route_bits;
		logic [ROUTE_MAX-1:0]  enable_reg;
		logic [WIDTH_W-1:0]    in_width [INPUT_CHANNELS_DEF];
		logic [WIDTH_W-1:0]    out_width [OUTPUTS_DEF];
		int unsigned           frame_pos;
		chain_t                chain;
		logic [FRAME_W-1:0]    startup_left;
		logic [PIN_W-1:0]      last_pins;
		result_t               due_results [$];
		int                    errors;

		function new();
			period_reg   = FRAME_PERIOD_RST;
			center_reg   = CENTER_RST;
			span_reg     = RANGE_RST;
			startup_reg  = STARTUP_RST;
			route_bits   = '0;
			enable_reg   = '0;
			foreach (in_width[i]) in_width[i] = RESET_WIDTH;
			foreach (out_width[i]) out_width[i] = RESET_WIDTH;
			frame_pos    = 0;
			chain        = '0;
			startup_left = STARTUP_RST;
			last_pins    = '0;
			errors       = 0;
		endfunction

		function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_FRAME_PERIOD: begin
					period_reg = data[FRAME_W-1:0];
				end
				REG_SERVO_CENTER: begin
					center_reg = data[CENTER_W-1:0];
				end
				REG_SERVO_RANGE: begin
					span_reg = data[CENTER_W-1:0];
				end
				REG_STARTUP_FRAMES: begin
					startup_reg  = data[FRAME_W-1:0];
					startup_left = data[FRAME_W-1:0];
				end
				REG_ROUTE_TABLE: begin
					route_bits = data;
				end
				REG_ROUTE_ENABLE: begin
					enable_reg = data[ROUTE_MAX-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		function logic [WIDTH_W-1:0] clamp_width(int v);
			int hi;
			int lo;
			hi = int'(center_reg) + int'(span_reg);
			lo = int'(center_reg) - int'(span_reg);
			if (hi > 8191) hi = 8191;
			if (lo < 0) lo = 0;
			// upper bound wins when the two cross
			if (v < lo) v = lo;
			if (v > hi) v = hi;
			return v[WIDTH_W-1:0];
		endfunction

		function void apply_routes();
			logic [ROUTE_BITS-1:0] bits;
			int ich;
			int och;
			int v;
			for (int r = 0; r < ROUTES_DEF; r++) begin
				bits = route_bits[ROUTE_BITS*r +: ROUTE_BITS];
				ich  = int'(bits[2:0]);
				och  = int'(bits[5:3]);
				if (!enable_reg[r]) continue;
				if (ich >= INPUT_CHANNELS_DEF || och >= OUTPUTS_DEF) continue;
				v = int'(in_width[ich]);
				if (bits[6]) v = 2 * int'(center_reg) - v;
				out_width[och] = clamp_width(v);
			end
		endfunction

		function void take_item(item_t it);
			result_t res;
			logic [PIN_W-1:0] pins;
			logic start;
			int unsigned period;
			if (it.action == ACT_LOAD) begin
				if (it.channel < INPUT_CHANNELS_DEF) in_width[it.channel] = it.width;
				res.pin_levels   = last_pins;
				res.frame_start  = 1'b0;
				res.startup_done = (startup_left == 0);
				due_results.push_back(res);
				return;
			end
			start = 1'b0;
			pins  = '0;
			if (frame_pos == 0) begin
				start = 1'b1;
				apply_routes();
				if (startup_left > 0) startup_left--;
				chain.index = CH_W'(CHAIN_FIRST);
				chain.count = '0;
			end
			for (int i = 0; i < CHAIN_FIRST; i++)
				if (frame_pos < out_width[i]) pins[i] = 1'b1;
			// zero-width chain outputs are skipped within the same tick
			for (int guard = 0; guard < 8 && chain.index != 0; guard++) begin
				if (chain.index >= OUTPUTS_DEF) begin
					chain.index = '0;
					break;
				end
				if (chain.count < out_width[chain.index]) break;
				chain.index++;
				chain.count = '0;
			end
			if (chain.index != 0) begin
				pins[chain.index] = 1'b1;
				chain.count++;
			end
			period    = (period_reg == 0) ? 1 : int'(period_reg);
			frame_pos = (frame_pos + 1 >= period) ? 0 : frame_pos + 1;
			last_pins = pins;
			res.pin_levels   = pins;
			res.frame_start  = start;
			res.startup_done = (startup_left == 0);
			due_results.push_back(res);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (due_results.size() == 0) begin
				$error("result with no item waiting: %0h", got);
				errors++;
				return;
			end
			want = due_results.pop_front();
			if (got.pin_levels !== want.pin_levels) begin
				$error("pin_levels: expected %0h, got %0h", want.pin_levels, got.pin_levels);
				errors++;
			end
			if (got.frame_start !== want.frame_start) begin
				$error("frame_start: expected %0b, got %0b", want.frame_start, got.frame_start);
				errors++;
			end
			if (got.startup_done !== want.startup_done) begin
				$error("startup_done: expected %0b, got %0b", want.startup_done,
					got.startup_done);
				errors++;
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   item_valid = 1'b0;
	logic                   item_stall;
	item_t                  item = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	result_t                result;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	frame_scoreboard sb = new();
	bit quiet = 1'b0;
	int idle_cycles = 0;

	servo_pulse_frame_generator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		result_stall <= !quiet && ($urandom_range(99) < 35);
	end

	// result checking and the no-progress watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) sb.check_result(result);
			if ((result_valid && !result_stall) || (item_valid && !item_stall) ||
					(cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
				$display("servo_pulse_frame_generator_tb: done, errors");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic send_item(input item_t it);
		while (!quiet && $urandom_range(99) < 35) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		sb.take_item(it);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (sb.due_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_config(input logic [FRAME_W-1:0] period,
			input logic [CENTER_W-1:0] center, input logic [CENTER_W-1:0] span,
			input logic [FRAME_W-1:0] startup, input logic [CFG_DATA_W-1:0] routes,
			input logic [ROUTE_MAX-1:0] enable);
		write_reg(REG_FRAME_PERIOD, CFG_DATA_W'(period));
		write_reg(REG_SERVO_CENTER, CFG_DATA_W'(center));
		write_reg(REG_SERVO_RANGE, CFG_DATA_W'(span));
		write_reg(REG_STARTUP_FRAMES, CFG_DATA_W'(startup));
		write_reg(REG_ROUTE_TABLE, routes);
		write_reg(REG_ROUTE_ENABLE, CFG_DATA_W'(enable));
		cfg_valid <= 1'b0;
	endtask

	function automatic item_t make_item(logic action, int ch, int w);
		item_t it;
		it.action  = action;
		it.channel = ch[CH_W-1:0];
		it.width   = w[WIDTH_W-1:0];
		return it;
	endfunction

	function automatic item_t random_item();
		int w;
		case ($urandom_range(9))
			0: w = $urandom_range(8191);
			1: w = $urandom_range(1) ? 8191 : 0;
			default: w = $urandom_range(80);
		endcase
		return make_item(($urandom_range(99) < 70) ? ACT_TICK : ACT_LOAD,
			$urandom_range(7), w);
	endfunction

	initial begin
		logic [FRAME_W-1:0]    period;
		logic [CENTER_W-1:0]   center;
		logic [CENTER_W-1:0]   span;
		logic [FRAME_W-1:0]    startup;
		logic [CFG_DATA_W-1:0] routes;
		logic [ROUTE_MAX-1:0]  enable;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// power-up settings: long frame, no routes
		send_item(make_item(ACT_TICK, 0, 0));
		send_item(make_item(ACT_LOAD, 7, 8191));
		send_item(make_item(ACT_LOAD, 0, 0));
		send_item(make_item(ACT_TICK, 7, 8191));
		send_item(make_item(ACT_TICK, 0, 0));
		send_item(make_item(ACT_LOAD, 5, 4096));
		drain();

		// short frames, tight clamp; mirror, absent output and zero widths
		load_config(16'd4, 12'd2, 12'd2, 16'd1,
			{7'b1_101_011, 7'b0_110_111, 7'b0_100_010, 7'b1_011_001, 7'b0_000_000},
			5'b11111);
		send_item(make_item(ACT_LOAD, 0, 0));
		send_item(make_item(ACT_LOAD, 1, 8191));
		send_item(make_item(ACT_LOAD, 2, 3));
		send_item(make_item(ACT_LOAD, 7, 8191));
		send_item(make_item(ACT_LOAD, 3, 0));
		send_item(make_item(ACT_LOAD, 4, 1));
		repeat (10) send_item(make_item(ACT_TICK, 0, 0));
		send_item(make_item(ACT_LOAD, 2, 4));
		repeat (2) send_item(make_item(ACT_TICK, 7, 8191));
		drain();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: period = '0;
				1: period = 16'd1;
				2: period = 16'hFFFF;
				default: period = FRAME_W'($urandom_range(3, 60));
			endcase
			if (p == 3) begin
				center = '0;
				span   = '0;
			end else if (p == 4) begin
				center = 12'hFFF;
				span   = 12'hFFF;
			end else begin
				center = CENTER_W'($urandom_range(50));
				span   = CENTER_W'($urandom_range(40));
			end
			case (p)
				1: startup = '0;
				5: startup = 16'hFFFF;
				default: startup = FRAME_W'($urandom_range(6));
			endcase
			routes = (p == 6) ? '1 : {3'($urandom), 32'($urandom)};
			case (p)
				6: enable = '1;
				7: enable = '0;
				default: enable = ROUTE_MAX'($urandom_range(31));
			endcase
			load_config(period, center, span, startup, routes, enable);
			quiet = (p == 3);
			repeat (PHASE_ITEMS) send_item(random_item());
			drain();
			quiet = 1'b0;
		end

		repeat (6) @(posedge clk);
		if (sb.due_results.size() != 0) begin
			$error("%0d results never arrived", sb.due_results.size());
			sb.errors++;
		end
		if (sb.errors == 0) begin
			$display("servo_pulse_frame_generator_tb: done, clean");
		end else begin
			$display("servo_pulse_frame_generator_tb: done, errors");
		end
		$finish;
	end

endmodule

[filelist.f]
hdl/spfg_pkg.sv
hdl/spfg_route.sv
hdl/spfg_pins.sv
hdl/servo_pulse_frame_generator.sv
dv/servo_pulse_frame_generator_tb.sv
